@@ src/rifoa_pkg.sv @@
package rifoa_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NONHEX  = 2'd1,
        ST_LENGTH  = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
        t_status     status;
    } t_result;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [1:0] FMT_RIC    = 2'd2;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] ch);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.value = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.value = 4'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.value = 4'(ch - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ src/rifoa_parse.sv @@
module rifoa_parse
    import rifoa_pkg::*;
#(
    parameter int FIRST_DIGITS  = 1,
    parameter int SECOND_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_start_req,
    input  logic [7:0]  i_character,
    input  logic [11:0] i_opcode,
    input  logic [1:0]  i_format,
    input  logic        i_no_m1,
    output t_result     o_result
);

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_ERROR  = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    localparam logic [2:0] FIRST_LIMIT  = 3'(FIRST_DIGITS);
    localparam logic [2:0] SECOND_LIMIT = 3'(SECOND_DIGITS);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_count, n_count;
    logic        r_bad, n_bad;
    logic [3:0]  r_first, n_first;
    logic [15:0] r_second, n_second;
    logic [11:0] r_opcode, n_opcode;
    t_status     r_err, n_err;

    // state as seen after an optional start
    t_phase      s_phase;
    logic [2:0]  s_count;
    logic        s_bad;
    logic [3:0]  s_first;
    logic [15:0] s_second;
    t_status     s_err;
    t_hex        hx;
    logic        fin;

    always_comb begin
        hx       = hex_decode(i_character);
        n_opcode = r_opcode;
        s_phase  = r_phase;
        s_count  = r_count;
        s_bad    = r_bad;
        s_first  = r_first;
        s_second = r_second;
        s_err    = r_err;
        if (i_start_req) begin
            n_opcode = i_opcode;
            s_count  = 3'd0;
            s_bad    = 1'b0;
            s_first  = 4'd0;
            s_second = 16'd0;
            s_err    = ST_OK;
            s_phase  = (i_format == FMT_RIC && i_no_m1) ? PH_SECOND : PH_FIRST;
        end
        n_phase  = s_phase;
        n_count  = s_count;
        n_bad    = s_bad;
        n_first  = s_first;
        n_second = s_second;
        n_err    = s_err;
        fin      = 1'b0;

        unique case (s_phase)
            PH_FIRST: begin
                if (i_character == CHAR_COMMA) begin
                    if (s_count == 3'd0) begin
                        n_err   = ST_MISSING;
                        n_phase = PH_ERROR;
                    end else if (s_bad) begin
                        n_err   = ST_NONHEX;
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_SECOND;
                        n_count = 3'd0;
                        n_bad   = 1'b0;
                    end
                end else if (i_character == CHAR_NUL) begin
                    n_err   = (s_count >= FIRST_LIMIT) ? ST_LENGTH : ST_MISSING;
                    n_phase = PH_IDLE;
                    fin     = 1'b1;
                end else if (s_count >= FIRST_LIMIT) begin
                    n_err   = ST_LENGTH;
                    n_phase = PH_ERROR;
                end else begin
                    n_count = s_count + 3'd1;
                    if (hx.is_hex) n_first = hx.value;
                    else n_bad = 1'b1;
                end
            end
            PH_SECOND: begin
                if (i_character == CHAR_NUL) begin
                    if (s_count == 3'd0) n_err = ST_MISSING;
                    else if (s_bad) n_err = ST_NONHEX;
                    n_phase = PH_IDLE;
                    fin     = 1'b1;
                end else if (s_count >= SECOND_LIMIT) begin
                    n_err   = ST_LENGTH;
                    n_phase = PH_ERROR;
                end else begin
                    n_count = s_count + 3'd1;
                    if (hx.is_hex) n_second = {s_second[11:0], hx.value};
                    else n_bad = 1'b1;
                end
            end
            PH_ERROR: begin
                if (i_character == CHAR_NUL) begin
                    n_phase = PH_IDLE;
                    fin     = 1'b1;
                end
            end
            PH_IDLE: begin
            end
            default: begin
            end
        endcase

        o_result.valid  = i_en && fin;
        o_result.status = n_err;
        o_result.word   = (n_err == ST_OK)
                        ? {n_opcode[11:4], n_first, n_opcode[3:0], n_second}
                        : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_count  <= 3'd0;
            r_bad    <= 1'b0;
            r_first  <= 4'd0;
            r_second <= 16'd0;
            r_opcode <= 12'd0;
            r_err    <= ST_OK;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_bad    <= n_bad;
            r_first  <= n_first;
            r_second <= n_second;
            r_opcode <= n_opcode;
            r_err    <= n_err;
        end
    end

endmodule

@@ src/ri_format_operand_assembler_top.sv @@
// Channel  Dir  tdata                                          tuser
// s_axis   in   [7:0] character, [19:8] opcode, [21:20] format, start_req
//               [22] no_m1, [23] pad
// m_axis   out  [31:0] machine_word                            [1:0] status
//
// One character per cycle when not stalled; a result leaves in the cycle
// after its NUL is taken. The parse state updates in the accept cycle, the
// result sits in one output register, so input stalls only while that
// register is full and not taken. Synchronous active-low reset returns the
// parser to the first field with a zero opcode and empties the output register.
module ri_format_operand_assembler_top
    import rifoa_pkg::*;
#(
    parameter int FIRST_DIGITS  = 1,
    parameter int SECOND_DIGITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // character, opcode, format, no_m1, pad
    input  logic        i_s_axis_tuser,   // start_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // machine_word
    output logic [1:0]  o_m_axis_tuser    // status
);

    logic        accept;
    t_result     res;
    logic        r_valid;
    logic [31:0] r_word;
    t_status     r_status;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    rifoa_parse #(
        .FIRST_DIGITS  (FIRST_DIGITS),
        .SECOND_DIGITS (SECOND_DIGITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_start_req (i_s_axis_tuser),
        .i_character (i_s_axis_tdata[7:0]),
        .i_opcode    (i_s_axis_tdata[19:8]),
        .i_format    (i_s_axis_tdata[21:20]),
        .i_no_m1     (i_s_axis_tdata[22]),
        .o_result    (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && o_s_axis_tready) begin
            r_word   <= res.word;
            r_status <= res.status;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_word;
    assign o_m_axis_tuser  = r_status;

endmodule
